[rtl/core/pli_pkg.sv]
// shared types and constants for the piecewise linear interpolator
package pli_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPAN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } pli_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic signed [31:0] table_min_x;
    logic signed [31:0] table_max_x;
    logic [1:0]         status;
  } pli_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_PAIR_LO,
    S_PAIR_HI,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FINISH,
    S_ENDS_LO,
    S_ENDS_HI,
    S_DONE
  } pli_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic search_init;
    logic search_rd;
    logic search_cmp;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic pair_lo;
    logic pair_hi;
    logic prep;
    logic mul;
    logic div_step;
    logic finish;
    logic ends_lo;
    logic ends_hi;
    logic emit;
  } pli_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       full;
    logic       few;
    logic       search_done;
    logic       shift_done;
    logic       span_bad;
    logic       div_done;
  } pli_stat_t;

endpackage

[rtl/core/pli_ctrl.sv]
// controller state machine for the piecewise linear interpolator
module pli_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pli_pkg::pli_stat_t stat,
  output pli_pkg::pli_cmd_t  cmd
);
  import pli_pkg::*;

  pli_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode_t'(stat.opcode))
            OP_INSERT: state_next = S_SEARCH_RD;
            OP_QUERY:  state_next = S_SEARCH_RD;
            default:   state_next = S_ENDS_LO;
          endcase
        end
      end
      S_SEARCH_RD: begin
        if (opcode_t'(stat.opcode) == OP_INSERT && stat.full) state_next = S_ENDS_LO;
        else if (opcode_t'(stat.opcode) == OP_QUERY && stat.few) state_next = S_ENDS_LO;
        else if (stat.search_done) begin
          if (opcode_t'(stat.opcode) == OP_INSERT) state_next = S_SHIFT_RD;
          else state_next = S_PAIR_LO;
        end else state_next = S_SEARCH_CMP;
      end
      S_SEARCH_CMP: state_next = S_SEARCH_RD;
      S_SHIFT_RD:   state_next = stat.shift_done ? S_INS_WR : S_SHIFT_WR;
      S_SHIFT_WR:   state_next = S_SHIFT_RD;
      S_INS_WR:     state_next = S_ENDS_LO;
      S_PAIR_LO:    state_next = S_PAIR_HI;
      S_PAIR_HI:    state_next = S_PREP;
      S_PREP:       state_next = stat.span_bad ? S_ENDS_LO : S_MUL;
      S_MUL:        state_next = S_DIV;
      S_DIV:        state_next = stat.div_done ? S_FINISH : S_DIV;
      S_FINISH:     state_next = S_ENDS_LO;
      S_ENDS_LO:    state_next = S_ENDS_HI;
      S_ENDS_HI:    state_next = S_DONE;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        cmd.search_init = start;
        cmd.clear = start && (opcode_t'(stat.opcode) == OP_CLEAR);
      end
      S_SEARCH_RD:  cmd.search_rd = 1'b1;
      S_SEARCH_CMP: cmd.search_cmp = 1'b1;
      S_SHIFT_RD:   cmd.shift_rd = 1'b1;
      S_SHIFT_WR:   cmd.shift_wr = 1'b1;
      S_INS_WR:     cmd.ins_wr = 1'b1;
      S_PAIR_LO:    cmd.pair_lo = 1'b1;
      S_PAIR_HI:    cmd.pair_hi = 1'b1;
      S_PREP:       cmd.prep = 1'b1;
      S_MUL:        cmd.mul = 1'b1;
      S_DIV:        cmd.div_step = 1'b1;
      S_FINISH:     cmd.finish = 1'b1;
      S_ENDS_LO:    cmd.ends_lo = 1'b1;
      S_ENDS_HI:    cmd.ends_hi = 1'b1;
      S_DONE:       cmd.emit = 1'b1;
      default:      cmd = '0;
    endcase
  end

endmodule

[rtl/core/pli_dp.sv]
// datapath: breakpoint memory, binary search, shifter and divider
module pli_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  pli_pkg::pli_in_t   in_item,
  input  pli_pkg::pli_cmd_t  cmd,
  output pli_pkg::pli_stat_t stat,
  output logic               done,
  output pli_pkg::pli_out_t  result
);
  import pli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0] mem [TABLE_DEPTH];
  logic [CW-1:0] count;
  pli_in_t item;

  logic [CW-1:0] lo, hi, mid_r, idx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data, rd_data;
  logic          wr_en;

  logic signed [31:0] xl, yl;
  logic signed [32:0] dx, dy, t;
  logic               neg, dyneg;
  logic [32:0]        mdy, mt;
  logic [65:0]        prod;
  logic [81:0]        num_a;
  logic [48:0]        num_b;
  logic [32:0]        rem_a, rem_b;
  logic [81:0]        qa;
  logic [48:0]        qb;
  logic [6:0]         dcnt;
  logic [1:0]         status;
  logic signed [31:0] value, slope, min_x, max_x;

  logic [CW-1:0] mid_c;
  assign mid_c = CW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  // upper entry of the segment: end pairs when the key is outside the table
  logic [CW-1:0] pair_hi_c;
  always_comb begin
    if (idx == count)     pair_hi_c = CW'(count - CW'(1));
    else if (idx == '0)   pair_hi_c = CW'(1);
    else                  pair_hi_c = idx;
  end

  // read address select
  always_comb begin
    rd_addr = '0;
    if (cmd.search_rd)      rd_addr = mid_c[AW-1:0];
    else if (cmd.shift_rd)  rd_addr = AW'(idx - CW'(1));
    else if (cmd.pair_lo)   rd_addr = AW'(pair_hi_c - CW'(1));
    else if (cmd.pair_hi)   rd_addr = idx[AW-1:0];
    else if (cmd.ends_lo)   rd_addr = '0;
    else if (cmd.ends_hi)   rd_addr = AW'(count - CW'(1));
  end

  always_comb begin
    wr_en = cmd.shift_wr || cmd.ins_wr;
    wr_addr = idx[AW-1:0];
    wr_data = cmd.ins_wr ? {item.point_x, item.point_y} : rd_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // pair compare: entry greater than key
  logic signed [31:0] key_x, key_y, ex, ey;
  logic gt;
  always_comb begin
    key_x = (opcode_t'(item.opcode) == OP_INSERT) ? item.point_x : item.query_x;
    key_y = (opcode_t'(item.opcode) == OP_INSERT) ? item.point_y : 32'sd0;
    ex = rd_data[63:32];
    ey = rd_data[31:0];
    gt = (ex > key_x) || (ex == key_x && ey > key_y);
  end

  // divider remainder steps for both quotients
  logic [33:0] ra_sh, rb_sh;
  logic [32:0] dxu;
  assign dxu = dx;
  assign ra_sh = {rem_a, num_a[81]};
  assign rb_sh = {rem_b, num_b[48]};

  assign prod = mdy * mt;

  function automatic logic signed [31:0] sat(input logic [40:0] m, input logic n,
                                             input logic signed [31:0] base);
    logic signed [42:0] s;
    s = 43'(base) + (n ? -43'($signed({2'b0, m})) : 43'($signed({2'b0, m})));
    if (s > 43'sd2147483647) return 32'sh7fffffff;
    if (s < -43'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      if (cmd.ins_wr) count <= CW'(count + CW'(1));
    end
    if (cmd.load) begin
      item <= in_item;
      status <= ST_OK;
      value <= '0;
      slope <= '0;
    end
    if (cmd.search_init) begin
      lo <= '0;
      hi <= count;
    end
    if (cmd.search_rd) begin
      mid_r <= mid_c;
      if (opcode_t'(item.opcode) == OP_INSERT && count >= CW'(TABLE_DEPTH))
        status <= ST_FULL;
      if (opcode_t'(item.opcode) == OP_QUERY && count < CW'(2))
        status <= ST_FEW;
      // insert walks down from the end of the table to the found slot
      idx <= (opcode_t'(item.opcode) == OP_INSERT) ? count : lo;
    end
    if (cmd.search_cmp) begin
      if (gt) hi <= mid_r;
      else    lo <= CW'(mid_r + CW'(1));
    end
    if (cmd.shift_wr) idx <= CW'(idx - CW'(1));
    if (cmd.pair_lo) idx <= pair_hi_c;
    if (cmd.pair_hi) begin
      xl <= rd_data[63:32];
      yl <= rd_data[31:0];
    end
    if (cmd.prep) begin
      dx <= 33'($signed(rd_data[63:32])) - 33'(xl);
      dy <= 33'($signed(rd_data[31:0])) - 33'(yl);
      t  <= 33'(item.query_x) - 33'(xl);
      if ($signed(rd_data[63:32]) <= xl) status <= ST_SPAN;
    end
    if (cmd.mul) begin
      mdy <= dy[32] ? 33'(-dy) : dy;
      mt  <= t[32] ? 33'(-t) : t;
      neg <= dy[32] ^ t[32];
      dyneg <= dy[32];
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (dcnt == '0) begin
        num_a <= 82'(prod);
        num_b <= {mdy[32:0], 16'd0};
        rem_a <= '0;
        rem_b <= '0;
        qa <= '0;
        qb <= '0;
      end else begin
        num_a <= {num_a[80:0], 1'b0};
        if (ra_sh >= {1'b0, dxu}) begin
          rem_a <= 33'(ra_sh - {1'b0, dxu});
          qa <= {qa[80:0], 1'b1};
        end else begin
          rem_a <= ra_sh[32:0];
          qa <= {qa[80:0], 1'b0};
        end
        if (dcnt <= 7'd49) begin
          num_b <= {num_b[47:0], 1'b0};
          if (rb_sh >= {1'b0, dxu}) begin
            rem_b <= 33'(rb_sh - {1'b0, dxu});
            qb <= {qb[47:0], 1'b1};
          end else begin
            rem_b <= rb_sh[32:0];
            qb <= {qb[47:0], 1'b0};
          end
        end
      end
      dcnt <= 7'(dcnt + 7'd1);
    end
    if (cmd.finish) begin
      value <= sat(41'(qa > 82'(41'h100_0000_0000) ? 82'(41'h100_0000_0000) : qa), neg, yl);
      slope <= sat(41'(qb > 49'(41'h100_0000_0000) ? 49'(41'h100_0000_0000) : qb), dyneg,
                   32'sd0);
    end
    if (cmd.ends_hi) min_x <= (count == '0) ? 32'sd0 : $signed(rd_data[63:32]);
    if (cmd.emit) max_x <= (count == '0) ? 32'sd0 : $signed(rd_data[63:32]);
  end

  assign stat.opcode = item.opcode;
  assign stat.full = count >= CW'(TABLE_DEPTH);
  assign stat.few = count < CW'(2);
  assign stat.search_done = (lo >= hi);
  assign stat.shift_done = (idx == lo);
  assign stat.span_bad = $signed(rd_data[63:32]) <= xl;
  assign stat.div_done = (dcnt == 7'd82);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit;
  end

  assign result.value = value;
  assign result.slope = slope;
  assign result.table_min_x = min_x;
  assign result.table_max_x = max_x;
  assign result.status = status;

endmodule

[rtl/core/piecewise_linear_interpolator.sv]
// top level of the piecewise linear interpolator
//
// channel | signals               | handshake
// input   | start, busy, in_item  | taken when start && !busy
// result  | done, result          | one cycle pulse, no back pressure
//
// clear and no-op go straight to reading the table ends; insert runs the
// binary search and then the shift; query runs the search, the segment reads
// and the one-bit-per-cycle divider
// the table shift on insert moves one entry at a time, a read state then a write state
// reset is synchronous and empties the table; busy is high until done
module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pli_pkg::pli_in_t  in_item,
  output logic              done,
  output pli_pkg::pli_out_t result
);
  import pli_pkg::*;

  pli_cmd_t  cmd;
  pli_stat_t stat, stat_mux;

  always_comb begin
    stat_mux = stat;
    if (!busy) stat_mux.opcode = in_item.opcode;
  end

  pli_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat_mux),
    .cmd  (cmd)
  );

  pli_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_item(in_item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule
